FILE: rtl/cpebp_pkg.sv
// ----------------------------------------------------------------------------
// cpebp_pkg
// Shared types and constants of the column-partitioned ELL bucket packer.
// ----------------------------------------------------------------------------
package cpebp_pkg;

    localparam int DEF_MAX_PARTS        = 8;
    localparam int DEF_MAX_BUCKETS      = 4;
    localparam int DEF_MAX_ROWS         = 1024;
    localparam int DEF_MAX_BUCKET_WIDTH = 32;
    localparam int DEF_COL_BITS         = 16;

    localparam int DEG_BITS  = 17;
    localparam int CFG_BITS  = 17;
    localparam int REG_BITS  = 3;
    localparam int ROW_BITS  = 10;
    localparam int NC_BITS   = 17;

    localparam logic [DEG_BITS-1:0] DEG_MAX = '1;

    typedef enum logic [1:0] {
        ACT_COUNT = 2'd0,
        ACT_PACK  = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [REG_BITS-1:0] {
        REG_NUM_COLS  = 3'd0,
        REG_NUM_PARTS = 3'd1,
        REG_NUM_BKTS  = 3'd2,
        REG_BW0       = 3'd3,
        REG_BW1       = 3'd4,
        REG_BW2       = 3'd5,
        REG_BW3       = 3'd6
    } reg_idx_t;

endpackage

FILE: rtl/cpebp_divider.sv
// ----------------------------------------------------------------------------
// cpebp_divider
// Restoring divider, one quotient bit per cycle, for the partition width and index.
// ----------------------------------------------------------------------------
module cpebp_divider
    import cpebp_pkg::*;
#(
    parameter int NB = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NB-1:0] dividend,
    input  logic [NB-1:0] divisor,
    output logic          done,
    output logic [NB-1:0] quotient
);
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] rem_reg, quo_reg, dvs_reg;
    logic [CB-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NB:0]   trial;

    assign trial    = {rem_reg, quo_reg[NB-1]} - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    // shift one bit a cycle, subtract when it fits; flag the final quotient
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CB'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(NB);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!trial[NB]) begin
                    rem_reg <= trial[NB-1:0];
                    quo_reg <= {quo_reg[NB-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[NB-2:0], quo_reg[NB-1]};
                    quo_reg <= {quo_reg[NB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CB'(1);
                if (cnt_reg == CB'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end
endmodule

FILE: rtl/column_partitioned_ell_bucket_packer.sv
// ----------------------------------------------------------------------------
// column_partitioned_ell_bucket_packer
// Packs CSR nonzeros into column-partitioned, degree-bucketed ELL slots.
// ----------------------------------------------------------------------------
// Sequence: a count item runs two 21-step passes of the shared bit-serial divider
// (partition width, then index) and then the degree memory read.
// A pack item does the same, then emits n slot elements (1 to 32), one per cycle while
// the output is not stalled; a flush emits only padding, a dropped request nothing.
// One item at a time; output stalls hold the emitter. After reset a clearing pass over
// all MAX_PARTS*MAX_ROWS entries zeroes the degree memory before the first item.
module column_partitioned_ell_bucket_packer
    import cpebp_pkg::*;
#(
    parameter int MAX_PARTS        = DEF_MAX_PARTS,
    parameter int MAX_BUCKETS      = DEF_MAX_BUCKETS,
    parameter int MAX_ROWS         = DEF_MAX_ROWS,
    parameter int MAX_BUCKET_WIDTH = DEF_MAX_BUCKET_WIDTH,
    parameter int COL_BITS         = DEF_COL_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [REG_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // action[1:0], row[11:2], col[27:12], flush_part[30:28], flush_bucket[32:31]
    input  logic [39:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // part[2:0], bucket[4:3], row_start[5], row_index[15:6], col_index[31:16],
    // mask[32]
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);
    localparam int PB   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int RB   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEP  = MAX_PARTS * MAX_ROWS;
    localparam int AB   = $clog2(DEP);
    localparam int NS   = MAX_PARTS * MAX_BUCKETS;
    localparam int SB   = (NS > 1) ? $clog2(NS) : 1;
    localparam int BB   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int WMAX = (MAX_BUCKET_WIDTH < 32) ? MAX_BUCKET_WIDTH : 32;
    localparam int BMAX = (MAX_BUCKETS < 4) ? MAX_BUCKETS : 4;
    localparam logic [15:0] COL_MASK = (COL_BITS >= 16) ? 16'hffff
                                                        : 16'((1 << COL_BITS) - 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_LOOK, ST_EMIT, ST_DONE
    } state_t;

    // ---------------- configuration registers
    logic [NC_BITS-1:0] num_cols_reg;
    logic [3:0]         num_parts_reg;
    logic [2:0]         num_bkts_reg;
    logic [5:0]         bw_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg  <= NC_BITS'(65536);
            num_parts_reg <= 4'd1;
            num_bkts_reg  <= 3'd4;
            bw_reg[0]     <= 6'd1;
            bw_reg[1]     <= 6'd2;
            bw_reg[2]     <= 6'd4;
            bw_reg[3]     <= 6'd8;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NUM_COLS:  num_cols_reg  <= cfg_wdata;
                REG_NUM_PARTS: num_parts_reg <= cfg_wdata[3:0];
                REG_NUM_BKTS:  num_bkts_reg  <= cfg_wdata[2:0];
                REG_BW0:       bw_reg[0]     <= cfg_wdata[5:0];
                REG_BW1:       bw_reg[1]     <= cfg_wdata[5:0];
                REG_BW2:       bw_reg[2]     <= cfg_wdata[5:0];
                REG_BW3:       bw_reg[3]     <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // clamped views of the registers
    logic [6:0] np;
    logic [2:0] nb;
    logic [NC_BITS-1:0] nc;
    logic [5:0] wid [4];
    always_comb begin
        np = (num_parts_reg == 4'd0) ? 7'd1 : 7'(num_parts_reg);
        if (np > 7'(MAX_PARTS)) np = 7'(MAX_PARTS);
        nb = (num_bkts_reg == 3'd0) ? 3'd1 : num_bkts_reg;
        if (nb > 3'(BMAX)) nb = 3'(BMAX);
        nc = (num_cols_reg == '0) ? NC_BITS'(1) : num_cols_reg;
        for (int i = 0; i < 4; i++) begin
            wid[i] = (bw_reg[i] == 6'd0) ? 6'd1 : bw_reg[i];
            if (wid[i] > 6'(WMAX)) wid[i] = 6'(WMAX);
        end
    end

    // ---------------- item registers
    state_t             state_reg;
    logic [1:0]         act_reg;
    logic [RB-1:0]      row_reg;
    logic [15:0]        col_reg;
    logic [PB-1:0]      part_reg;
    logic [1:0]         bkt_reg;
    logic [AB-1:0]      clr_reg;
    logic [5:0]         pad_reg;     // padding elements still to emit
    logic               real_reg;    // a real nonzero follows the padding
    logic               rs_reg;
    logic [5:0]         fnew_reg;

    // per-stream state
    logic [5:0]    fill_reg [NS];
    logic [RB-1:0] orow_reg [NS];

    // degree memory
    logic [DEG_BITS-1:0] deg_mem [DEP];
    logic [DEG_BITS-1:0] deg_rd_reg;

    // ---------------- divider for the partition width and index
    logic                div_start, div_done;
    logic [NC_BITS-1:0]  div_q;
    logic [20:0]         div_q_w;
    logic [NC_BITS-1:0]  pw;
    logic [NC_BITS+3:0]  pw_sum;
    logic                div_phase_reg;   // 0 width, 1 index
    logic [NC_BITS-1:0]  pw_reg;

    assign pw_sum = 21'(nc) + 21'(np) - 21'd1;
    // ceil(nc/np): np is at most 8 distinct values; do it on the shared divider
    assign pw = pw_reg;

    cpebp_divider #(.NB(21)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_phase_reg ? 21'(col_reg) : pw_sum),
        .divisor  (div_phase_reg ? 21'(pw) : 21'(np)),
        .done     (div_done),
        .quotient (div_q_w)
    );
    assign div_q = div_q_w[NC_BITS-1:0];

    logic div_go_reg;
    assign div_start = div_go_reg;

    // bucket choice from the registered degree read
    logic [1:0] bsel;
    always_comb begin
        bsel = 2'(nb - 3'd1);
        for (int i = BMAX - 1; i >= 0; i--) begin
            if (3'(i) < nb && 17'(wid[i]) >= deg_rd_reg) bsel = 2'(i);
        end
    end

    logic [SB-1:0] sidx;
    assign sidx = SB'(part_reg * MAX_BUCKETS + BB'(bkt_reg));

    logic out_valid_reg, out_last_reg, out_rs_reg, out_mask_reg;
    logic [RB-1:0] out_row_reg;
    logic [15:0]   out_col_reg;
    logic [PB-1:0] out_part_reg;
    logic [1:0]    out_bkt_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_mask_reg, out_col_reg, 10'(out_row_reg), out_rs_reg,
                       out_bkt_reg, 3'(out_part_reg)};

    logic [PB-1:0] part_calc;
    always_comb begin
        if (17'(col_reg) >= nc || div_q >= NC_BITS'(np)) part_calc = PB'(np - 7'd1);
        else part_calc = PB'(div_q);
    end

    // ---------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                fill_reg[i] <= '0;
                orow_reg[i] <= '0;
            end
        end else begin
            div_go_reg <= 1'b0;
            // drop the taken result unless the emitter refills it
            if (out_valid_reg && m_tready && state_reg != ST_EMIT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AB'(1);
                    if (clr_reg == AB'(DEP - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg  <= s_tdata[1:0];
                        row_reg  <= RB'(s_tdata[11:2]);
                        col_reg  <= s_tdata[27:12] & COL_MASK;
                        part_reg <= PB'(s_tdata[30:28]);
                        bkt_reg  <= s_tdata[32:31];
                        unique case (action_t'(s_tdata[1:0]))
                            ACT_COUNT, ACT_PACK: begin
                                div_phase_reg <= 1'b0;
                                div_go_reg    <= 1'b1;
                                state_reg     <= ST_DIV;
                            end
                            ACT_FLUSH: begin
                                if (7'(s_tdata[30:28]) < np && 3'(s_tdata[32:31]) < nb)
                                    state_reg <= ST_LOOK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_done && !div_go_reg) begin
                        if (!div_phase_reg) begin
                            pw_reg        <= div_q;
                            div_phase_reg <= 1'b1;
                            div_go_reg    <= 1'b1;
                        end else begin
                            part_reg  <= part_calc;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    // degree memory read data lands next cycle
                    state_reg <= ST_LOOK;
                    bkt_reg   <= 2'd0;
                end
                ST_LOOK: begin
                    if (action_t'(act_reg) == ACT_COUNT) begin
                        state_reg <= ST_IDLE;
                    end else if (action_t'(act_reg) == ACT_FLUSH) begin
                        real_reg <= 1'b0;
                        if (fill_reg[sidx] != 6'd0 && fill_reg[sidx] < wid[bkt_reg]) begin
                            pad_reg   <= wid[bkt_reg] - fill_reg[sidx];
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                        fill_reg[sidx] <= '0;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // pack: stream chosen in bkt_reg
                    real_reg  <= 1'b1;
                    state_reg <= ST_EMIT;
                    if (fill_reg[sidx] >= wid[bkt_reg] || fill_reg[sidx] == 6'd0) begin
                        pad_reg  <= '0;
                        rs_reg   <= 1'b1;
                        fnew_reg <= 6'd1;
                    end else if (row_reg != orow_reg[sidx]) begin
                        pad_reg  <= wid[bkt_reg] - fill_reg[sidx];
                        rs_reg   <= 1'b1;
                        fnew_reg <= 6'd1;
                    end else begin
                        pad_reg  <= '0;
                        rs_reg   <= 1'b0;
                        fnew_reg <= fill_reg[sidx] + 6'd1;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_part_reg  <= part_reg;
                        out_bkt_reg   <= bkt_reg;
                        if (pad_reg != 6'd0) begin
                            out_rs_reg   <= 1'b0;
                            out_row_reg  <= '0;
                            out_col_reg  <= '0;
                            out_mask_reg <= 1'b0;
                            out_last_reg <= (pad_reg == 6'd1) && !real_reg;
                            pad_reg      <= pad_reg - 6'd1;
                            if (pad_reg == 6'd1 && !real_reg) state_reg <= ST_IDLE;
                        end else begin
                            out_rs_reg   <= rs_reg;
                            out_row_reg  <= rs_reg ? row_reg : '0;
                            out_col_reg  <= col_reg;
                            out_mask_reg <= 1'b1;
                            out_last_reg <= 1'b1;
                            if (rs_reg) orow_reg[sidx] <= row_reg;
                            fill_reg[sidx] <= (fnew_reg >= wid[bkt_reg]) ? 6'd0 : fnew_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // bucket chosen once degree is registered
            if (state_reg == ST_LOOK && action_t'(act_reg) == ACT_PACK) bkt_reg <= bsel;
        end
    end

    // degree memory: clear sweep, read, increment
    logic [AB-1:0] deg_addr;
    assign deg_addr = AB'(part_reg * MAX_ROWS + RB'(row_reg));
    always_ff @(posedge aclk) begin
        deg_rd_reg <= deg_mem[deg_addr];
        if (state_reg == ST_CLEAR) begin
            deg_mem[clr_reg] <= '0;
        end else if (state_reg == ST_LOOK && action_t'(act_reg) == ACT_COUNT
                     && deg_rd_reg != DEG_MAX) begin
            deg_mem[deg_addr] <= deg_rd_reg + DEG_BITS'(1);
        end
    end

endmodule

FILE: dv/column_partitioned_ell_bucket_packer_tb.sv
// ----------------------------------------------------------------------------
// column_partitioned_ell_bucket_packer_tb
// Streams count, pack and flush requests through the ELL bucket packer under
// several register settings, predicts every emitted slot element in a local
// model of the degree store and the per-stream slot fill, and compares each
// result field by field with random idling on both channels.
// ----------------------------------------------------------------------------
module column_partitioned_ell_bucket_packer_tb;
    import cpebp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPARTS      = DEF_MAX_PARTS;
    localparam int NBKTS       = DEF_MAX_BUCKETS;
    localparam int NROWS       = DEF_MAX_ROWS;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [2:0]  part;
        logic [1:0]  bucket;
        logic        row_start;
        logic [9:0]  row_index;
        logic [15:0] col_index;
        logic        mask;
        logic        last;
    } slot_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [REG_BITS-1:0] cfg_addr;
    logic [CFG_BITS-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;
    logic                m_tlast;

    column_partitioned_ell_bucket_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic [CFG_BITS-1:0] regs [7];
    logic [16:0]         degree [NPARTS*NROWS];
    int unsigned         fill [NPARTS*NBKTS];
    logic [9:0]          open_row [NPARTS*NBKTS];

    logic [39:0] request_q [$];
    slot_t       slot_q [$];
    int          errors;
    bit          hold_off;
    bit          hold_req;

    function automatic int unsigned parts_used();
        int unsigned n = regs[REG_NUM_PARTS];
        if (n == 0) n = 1;
        if (n > NPARTS) n = NPARTS;
        return n;
    endfunction

    function automatic int unsigned buckets_used();
        int unsigned n = regs[REG_NUM_BKTS];
        if (n == 0) n = 1;
        if (n > NBKTS) n = NBKTS;
        return n;
    endfunction

    function automatic int unsigned slot_width(int unsigned b);
        int unsigned w = regs[REG_BW0 + b] & 6'h3f;
        if (w == 0) w = 1;
        if (w > 32) w = 32;
        return w;
    endfunction

    function automatic int unsigned part_of(int unsigned col);
        int unsigned np = parts_used();
        int unsigned nc = regs[REG_NUM_COLS];
        int unsigned p;
        if (nc == 0) nc = 1;
        if (col >= nc) return np - 1;
        p = col / ((nc + np - 1) / np);
        if (p >= np) p = np - 1;
        return p;
    endfunction

    function automatic void add_request(logic [39:0] d);
        request_q = {request_q, d};
    endfunction

    function automatic void push_slot(int unsigned p, int unsigned b, bit rs,
                                      int unsigned r, int unsigned c, bit m);
        slot_t s;
        s.part = 3'(p); s.bucket = 2'(b); s.row_start = rs;
        s.row_index = 10'(r); s.col_index = 16'(c); s.mask = m; s.last = 1'b0;
        slot_q = {slot_q, s};
    endfunction

    function automatic void pad_stream(int unsigned p, int unsigned b);
        int unsigned s = p*NBKTS + b;
        int unsigned w = slot_width(b);
        int unsigned f = fill[s];
        if (f != 0 && f < w) begin
            for (; f < w; f++) push_slot(p, b, 0, 0, 0, 0);
        end
        fill[s] = 0;
    endfunction

    // work out the slot elements one accepted request emits
    function automatic void predict_slots(logic [39:0] d);
        action_t     act = action_t'(d[1:0]);
        int unsigned row = d[11:2];
        int unsigned col = d[27:12];
        int unsigned n0 = slot_q.size();
        int unsigned p, b, s, w, f, deg, nb;
        case (act)
            ACT_COUNT: begin
                s = part_of(col)*NROWS + row;
                if (degree[s] != DEG_MAX) degree[s]++;
            end
            ACT_PACK: begin
                p = part_of(col);
                deg = degree[p*NROWS + row];
                nb = buckets_used();
                b = nb - 1;
                for (int i = nb - 1; i >= 0; i--) if (slot_width(i) >= deg) b = i;
                s = p*NBKTS + b;
                w = slot_width(b);
                f = fill[s];
                if (f >= w) begin f = 0; fill[s] = 0; end
                if (f != 0 && row != open_row[s]) begin
                    pad_stream(p, b);
                    f = 0;
                end
                if (f == 0) begin
                    open_row[s] = 10'(row);
                    push_slot(p, b, 1, row, col, 1);
                end else begin
                    push_slot(p, b, 0, 0, col, 1);
                end
                f++;
                fill[s] = (f >= w) ? 0 : f;
            end
            ACT_FLUSH: begin
                if (d[30:28] < parts_used() && d[32:31] < buckets_used())
                    pad_stream(d[30:28], d[32:31]);
            end
            default: ;
        endcase
        if (slot_q.size() > n0) slot_q[slot_q.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [39:0] make_request(action_t a, int unsigned row,
                                                 int unsigned col, int unsigned fp,
                                                 int unsigned fb);
        logic [39:0] d = '0;
        d[1:0] = a; d[11:2] = 10'(row); d[27:12] = 16'(col);
        d[30:28] = 3'(fp); d[32:31] = 2'(fb);
        return d;
    endfunction

    function automatic int unsigned short_or_long_gap();
        if ($urandom_range(9) < 5) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(40, 10);
        return $urandom_range(3);
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // driver: offer queued requests at the falling edge
    int unsigned drv_gap;
    logic s_tready_q;
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        drv_gap = 0;
    end
    always @(negedge aclk) begin
        if (s_tvalid && s_tready && aresetn) begin
            // accepted at the last rising edge
        end
        if (!(s_tvalid && !s_tready_q)) begin
            if (drv_gap != 0) begin
                drv_gap <= drv_gap - 1;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                s_tdata <= request_q.pop_front();
                s_tvalid <= 1'b1;
                drv_gap <= short_or_long_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // note whether the request on the bus was taken at the last rising edge
    always @(posedge aclk) begin
        s_tready_q <= s_tready & aresetn;
        if (aresetn && s_tvalid && s_tready) begin
            predict_slots(s_tdata);
        end
    end

    // receiver hold-off: once asked for, refuse results for a long stretch
    initial begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // receiver stalls
    int unsigned rcv_gap;
    initial begin
        m_tready = 1'b0;
        rcv_gap = 0;
    end
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (rcv_gap != 0) begin
            rcv_gap <= rcv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rcv_gap <= short_or_long_gap();
        end
    end

    // monitor: compare each taken result with the oldest expectation
    always @(posedge aclk) begin
        slot_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[4:3], m_tdata[5], m_tdata[15:6],
                   m_tdata[31:16], m_tdata[32], m_tlast};
            if (slot_q.size() == 0) begin
                $display("%0t: unexpected slot %h", $time, got);
                errors++;
            end else begin
                want = slot_q.pop_front();
                if (got.part !== want.part)
                    $display("%0t: part exp %0d got %0d", $time, want.part, got.part);
                if (got.bucket !== want.bucket)
                    $display("%0t: bucket exp %0d got %0d", $time, want.bucket, got.bucket);
                if (got.row_start !== want.row_start)
                    $display("%0t: row_start exp %0d got %0d", $time,
                             want.row_start, got.row_start);
                if (got.row_index !== want.row_index)
                    $display("%0t: row_index exp %0d got %0d", $time,
                             want.row_index, got.row_index);
                if (got.col_index !== want.col_index)
                    $display("%0t: col_index exp %0d got %0d", $time,
                             want.col_index, got.col_index);
                if (got.mask !== want.mask)
                    $display("%0t: mask exp %0d got %0d", $time, want.mask, got.mask);
                if (got.last !== want.last)
                    $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                if (got !== want) errors++;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_BITS'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        regs[idx] = CFG_BITS'(val);
    endtask

    // wait until every queued request is taken and every slot has come back
    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || slot_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // one phase: count pass then pack pass over a random sparse matrix, then flushes
    task automatic matrix_phase(int unsigned nnz, int unsigned nrows,
                                int unsigned ncols);
        int unsigned rows [$];
        int unsigned cols [$];
        int unsigned r, k;
        for (int i = 0; i < nnz; i++) begin
            r = $urandom_range(nrows - 1) + $urandom_range(1) * (NROWS - nrows);
            k = $urandom_range(4) + 1;
            for (int j = 0; j < k && rows.size() < nnz; j++) begin
                rows = {rows, r};
                cols = {cols, ($urandom_range(3) == 0 ? $urandom : $urandom_range(ncols))};
            end
            if (rows.size() >= nnz) break;
        end
        foreach (rows[i]) add_request(make_request(ACT_COUNT, rows[i], cols[i], 0, 0));
        foreach (rows[i]) begin
            if ($urandom_range(15) == 0)
                add_request(make_request(action_t'($urandom_range(3)),
                                         $urandom, $urandom, $urandom, $urandom));
            add_request(make_request(ACT_PACK, rows[i], cols[i], 0, 0));
        end
        // flush every bucket of each part in use, plus one flush of the last part's last bucket
        for (int p = 0; p < int'(parts_used()); p++)
            for (int b = 0; b < NBKTS; b++)
                add_request(make_request(ACT_FLUSH, $urandom, $urandom, p, b));
        add_request(make_request(ACT_FLUSH, $urandom, $urandom, NPARTS - 1, NBKTS - 1));
    endtask

    initial begin
        int unsigned nc;
        errors = 0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;
        regs[REG_NUM_COLS] = 65536; regs[REG_NUM_PARTS] = 1; regs[REG_NUM_BKTS] = 4;
        regs[REG_BW0] = 1; regs[REG_BW1] = 2; regs[REG_BW2] = 4; regs[REG_BW3] = 8;
        foreach (degree[i]) degree[i] = '0;
        foreach (fill[i]) begin fill[i] = 0; open_row[i] = '0; end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, field extremes, every action, odd cases
        add_request(make_request(ACT_COUNT, 0, 0, 0, 0));
        add_request(make_request(ACT_COUNT, 1023, 16'hffff, 0, 0));
        add_request(make_request(ACT_COUNT, 1023, 16'hffff, 0, 0));
        add_request(make_request(ACT_PACK, 0, 0, 0, 0));
        add_request(make_request(ACT_PACK, 1023, 16'hffff, 0, 0));
        add_request(make_request(ACT_PACK, 5, 123, 0, 0));
        add_request(make_request(ACT_PACK, 5, 124, 0, 0));
        add_request(make_request(ACT_PACK, 1023, 16'hfffe, 0, 0));
        add_request(make_request(ACT_NONE, 1023, 16'hffff, 7, 3));
        add_request(make_request(ACT_FLUSH, 0, 0, 7, 3));
        add_request(make_request(ACT_FLUSH, 0, 0, 0, 1));
        add_request(make_request(ACT_FLUSH, 0, 0, 0, 0));
        add_request(make_request(ACT_FLUSH, 1023, 16'hffff, 0, 3));
        wait_idle();

        // widest settings, with a long receiver hold-off to back up the input
        write_reg(REG_NUM_COLS, 100);
        write_reg(REG_NUM_PARTS, 8);
        write_reg(REG_NUM_BKTS, 4);
        write_reg(REG_BW0, 2);
        write_reg(REG_BW1, 5);
        write_reg(REG_BW2, 16);
        write_reg(REG_BW3, 32);
        hold_req = 1'b1;
        matrix_phase(40, 12, 110);
        wait_idle();

        // lower widths so stale fills close without padding, odd register values
        write_reg(REG_BW3, 3);
        write_reg(REG_BW2, 0);
        write_reg(REG_NUM_PARTS, 0);
        write_reg(REG_NUM_BKTS, 7);
        write_reg(REG_NUM_COLS, 0);
        add_request(make_request(ACT_PACK, 3, 9, 0, 0));
        add_request(make_request(ACT_PACK, 1023, 16'hffff, 0, 0));
        matrix_phase(12, 4, 3);
        wait_idle();

        // random settings
        for (int ph = 0; ph < 2; ph++) begin
            nc = $urandom_range(3) == 0 ? 131071 : $urandom_range(300, 1);
            write_reg(REG_NUM_COLS, nc);
            write_reg(REG_NUM_PARTS, $urandom_range(15));
            write_reg(REG_NUM_BKTS, $urandom_range(7));
            write_reg(REG_BW0, $urandom_range(3, 1));
            write_reg(REG_BW1, $urandom_range(8, 2));
            write_reg(REG_BW2, $urandom_range(20, 4));
            write_reg(REG_BW3, $urandom_range(63));
            matrix_phase(16, 10, nc > 400 ? 400 : nc + 20);
            wait_idle();
        end

        if (errors == 0 && slot_q.size() == 0) begin
            $display("column_partitioned_ell_bucket_packer_tb OK");
        end else begin
            $display("column_partitioned_ell_bucket_packer_tb NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("column_partitioned_ell_bucket_packer_tb NOT OK");
        $finish;
    end

endmodule

FILE: column_partitioned_ell_bucket_packer.f
rtl/cpebp_pkg.sv
rtl/cpebp_divider.sv
rtl/column_partitioned_ell_bucket_packer.sv
dv/column_partitioned_ell_bucket_packer_tb.sv
